// ===== hw/rtl/iprb_pkg.sv =====
package iprb_pkg;

  // field widths of the request and result items
  localparam int unsigned FIRST_W  = 16;
  localparam int unsigned COUNT_W  = 17;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned VALUE_W  = 64;

  // port positions and range ends, with room for base plus one word
  localparam int unsigned SPAN_W   = 18;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_NOPERM  = 2'd2
  } status_e;

  // what the word unit reports about the word at the current base
  typedef struct packed {
    logic touched;
    logic last;
  } word_info_t;

endpackage

// ===== hw/rtl/iprb_if.sv =====
interface iprb_req_if;
  logic                         valid;
  logic                         ready;
  logic [iprb_pkg::FIRST_W-1:0] first_port;
  logic [iprb_pkg::COUNT_W-1:0] port_count;
  logic                         grant;
  logic                         privileged;

  modport source (output valid, first_port, port_count, grant, privileged, input ready);
  modport sink   (input valid, first_port, port_count, grant, privileged, output ready);
endinterface

interface iprb_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [iprb_pkg::STATUS_W-1:0] status;
  logic [iprb_pkg::INDEX_W-1:0]  word_index;
  logic [iprb_pkg::VALUE_W-1:0]  word_value;
  logic                          last;

  modport source (output valid, status, word_index, word_value, last, input ready);
  modport sink   (input valid, status, word_index, word_value, last, output ready);
endinterface

// ===== hw/rtl/io_permission_bitmap_range_update.sv =====
// port permission bitmap, range update. PORT_TOTAL ports are kept in
// PORT_TOTAL/WORD_BITS words of WORD_BITS bits, a set bit meaning the port is
// denied. after reset a clearing pass writes all ones into every word, one word
// a cycle, so the block takes no request until that pass is done.
// a request clears (grant) or sets (revoke) the bits of
// [first_port, first_port + port_count). an empty range or one past the end
// gives a single invalid-range item, an unprivileged grant a single
// not-permitted item; otherwise one item comes out for each touched word, in
// ascending word order, carrying the new word content, with last on the final
// one. a request is handled alone by a small sequencer around one word unit and
// a bitmap memory with one write and one read port: an accept step, a check
// step, then a scan step for each word below the range, and per touched word a
// read step, a modify and write step and a step holding the result item until
// it is taken. a rejected request goes from the check step to its result item
module io_permission_bitmap_range_update #(
  parameter int unsigned PORT_TOTAL = 1024,
  parameter int unsigned WORD_BITS  = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  iprb_req_if.sink   req_i,
  iprb_rsp_if.source rsp_o
);
  import iprb_pkg::*;

  localparam int unsigned WORD_COUNT = PORT_TOTAL / WORD_BITS;
  localparam int unsigned IDX_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_MOD,
    S_OUT
  } state_e;

  state_e                state_q, state_d;
  logic [IDX_W-1:0]      w_q, w_d;
  logic [SPAN_W-1:0]     base_q, base_d;
  logic [SPAN_W-1:0]     end_q, end_d;
  logic [FIRST_W-1:0]    first_q, first_d;
  logic [COUNT_W-1:0]    count_q, count_d;
  logic                  grant_q, grant_d;
  logic                  priv_q, priv_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [INDEX_W-1:0]    index_q, index_d;
  logic [VALUE_W-1:0]    value_q, value_d;
  logic                  last_q, last_d;

  // bitmap memory port
  logic                  ram_we;
  logic [WORD_BITS-1:0]  ram_wdata;
  logic [WORD_BITS-1:0]  ram_rdata;

  // word unit
  word_info_t            info;
  logic [WORD_BITS-1:0]  mask;
  logic [WORD_BITS-1:0]  new_word;

  logic [SPAN_W-1:0]     range_end;
  logic                  range_bad;
  logic                  w_final;

  iprb_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(w_q),
    .wdata_i(ram_wdata),
    .raddr_i(w_q),
    .rdata_o(ram_rdata)
  );

  iprb_word_unit #(
    .WORD_BITS(WORD_BITS)
  ) u_word (
    .base_i (base_q),
    .first_i(first_q),
    .end_i  (end_q),
    .info_o (info),
    .mask_o (mask)
  );

  // range check on the latched request
  assign range_end = SPAN_W'(first_q) + SPAN_W'(count_q);
  assign range_bad = (count_q == '0) || (range_end > SPAN_W'(PORT_TOTAL));
  assign w_final   = (w_q == IDX_W'(WORD_COUNT - 1));

  // grant clears the covered bits, revoke sets them
  assign new_word  = grant_q ? (ram_rdata & ~mask) : (ram_rdata | mask);
  assign ram_we    = (state_q == S_CLEAR) || (state_q == S_MOD);
  assign ram_wdata = (state_q == S_CLEAR) ? '1 : new_word;

  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = (state_q == S_OUT);
  assign rsp_o.status     = status_q;
  assign rsp_o.word_index = index_q;
  assign rsp_o.word_value = value_q;
  assign rsp_o.last       = last_q;

  always_comb begin
    state_d  = state_q;
    w_d      = w_q;
    base_d   = base_q;
    end_d    = end_q;
    first_d  = first_q;
    count_d  = count_q;
    grant_d  = grant_q;
    priv_d   = priv_q;
    status_d = status_q;
    index_d  = index_q;
    value_d  = value_q;
    last_d   = last_q;

    case (state_q)
      S_CLEAR: begin
        // one word of all ones a cycle
        if (w_final) begin
          w_d     = '0;
          state_d = S_IDLE;
        end else begin
          w_d = w_q + IDX_W'(1);
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          first_d = req_i.first_port;
          count_d = req_i.port_count;
          grant_d = req_i.grant;
          priv_d  = req_i.privileged;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        w_d    = '0;
        base_d = '0;
        end_d  = range_end;
        if (range_bad || (grant_q && !priv_q)) begin
          // error item: index and value read zero
          status_d = range_bad ? STATUS_INVALID : STATUS_NOPERM;
          index_d  = '0;
          value_d  = '0;
          last_d   = 1'b1;
          state_d  = S_OUT;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // memory read of word w_q is under way when the word is touched
        if (info.touched) begin
          state_d = S_MOD;
        end else if (w_final) begin
          state_d = S_IDLE;
        end else begin
          w_d    = w_q + IDX_W'(1);
          base_d = base_q + SPAN_W'(WORD_BITS);
        end
      end
      S_MOD: begin
        status_d = STATUS_DONE;
        index_d  = INDEX_W'(w_q);
        value_d  = VALUE_W'(new_word);
        last_d   = info.last;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (rsp_o.ready) begin
          if (last_q || w_final) begin
            state_d = S_IDLE;
          end else begin
            w_d     = w_q + IDX_W'(1);
            base_d  = base_q + SPAN_W'(WORD_BITS);
            state_d = S_SCAN;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      w_q      <= '0;
      base_q   <= '0;
      end_q    <= '0;
      first_q  <= '0;
      count_q  <= '0;
      grant_q  <= 1'b0;
      priv_q   <= 1'b0;
      status_q <= '0;
      index_q  <= '0;
      value_q  <= '0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      w_q      <= w_d;
      base_q   <= base_d;
      end_q    <= end_d;
      first_q  <= first_d;
      count_q  <= count_d;
      grant_q  <= grant_d;
      priv_q   <= priv_d;
      status_q <= status_d;
      index_q  <= index_d;
      value_q  <= value_d;
      last_q   <= last_d;
    end
  end

endmodule

// ===== hw/rtl/iprb_ram.sv =====
module iprb_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hw/rtl/iprb_word_unit.sv =====
module iprb_word_unit #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic [iprb_pkg::SPAN_W-1:0]  base_i,
  input  logic [iprb_pkg::FIRST_W-1:0] first_i,
  input  logic [iprb_pkg::SPAN_W-1:0]  end_i,
  output iprb_pkg::word_info_t         info_o,
  output logic [WORD_BITS-1:0]         mask_o
);
  import iprb_pkg::*;

  localparam int unsigned BIT_W = $clog2(WORD_BITS + 1);

  logic [SPAN_W-1:0] first_x;
  logic [SPAN_W-1:0] word_bits_x;
  logic [SPAN_W-1:0] top;
  logic [SPAN_W-1:0] lo_full;
  logic [SPAN_W-1:0] hi_full;
  logic [BIT_W-1:0]  lo;
  logic [BIT_W-1:0]  hi;

  assign first_x     = SPAN_W'(first_i);
  assign word_bits_x = SPAN_W'(WORD_BITS);
  assign top         = base_i + word_bits_x;

  // covered bit span inside this word, as [lo, hi)
  assign lo_full = (first_x > base_i) ? (first_x - base_i) : '0;
  assign hi_full = (end_i < top) ? (end_i - base_i) : word_bits_x;
  assign lo      = lo_full[BIT_W-1:0];
  assign hi      = hi_full[BIT_W-1:0];

  assign info_o.touched = (base_i < end_i) && (top > first_x);
  assign info_o.last    = (end_i <= top);

  always_comb begin
    for (int i = 0; i < int'(WORD_BITS); i++) begin
      mask_o[i] = (BIT_W'(i) >= lo) && (BIT_W'(i) < hi);
    end
  end

endmodule
